@@ rtl/cqrev_pkg.sv @@
// Shared types for the circular queue with in-place reverse.
// Command and status codes, and the item and result transfer structs.
// No dependencies.
package cqrev_pkg;

    typedef enum logic [1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_REV = 2'd2,
        CMD_CLR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 7;

    typedef struct packed {
        cmd_t                      cmd;
        logic signed [DATA_W-1:0]  data_in;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  data_out;
        status_t                   status;
        logic                      is_empty;
        logic        [COUNT_W-1:0] fill_count;
    } result_t;

endpackage

@@ rtl/circular_queue_with_reverse_top.sv @@
// Circular FIFO of signed words with dequeue, in-place reverse and clear.
// Uses cqrev_pkg for the command/status codes and the transfer structs.
// Holds the slot memory, the pointers and the command sequencer.

// Usage: a command transfers when start is high and busy is low; its single
// result appears in the cycle after the command completes, for exactly one
// cycle with done high, and must be taken then, since the block never waits
// for the receiver.
// Enqueue, clear and any rejected command keep busy low, and a new command
// may follow at once. A successful dequeue passes through the S_DEQ state
// because the slot memory has a registered read port. Reverse swaps
// floor(n/2) pairs for n held entries: each swap goes through the
// memory's one read and one write port as read low, read high, write low,
// write high. The queue holds at most DEPTH-1 words; fill_count carries the
// low 7 bits of the count. No clearing pass follows reset.
module circular_queue_with_reverse_top #(
    parameter int unsigned DEPTH     = 128,
    parameter int unsigned WORD_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  cqrev_pkg::item_t   item,
    output logic               busy,
    output logic               done,
    output cqrev_pkg::result_t result
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned DW    = cqrev_pkg::DATA_W;
    localparam int unsigned CW    = cqrev_pkg::COUNT_W;
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEQ,
        S_REV_RD_LO,
        S_REV_RD_HI,
        S_REV_WR_LO,
        S_REV_WR_HI
    } state_t;

    function automatic logic [PTR_W-1:0] next_idx(input logic [PTR_W-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] prev_idx(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_IDX : p - 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] held(input logic [PTR_W-1:0] h,
                                               input logic [PTR_W-1:0] t);
        logic [PTR_W:0] diff;
        diff = {1'b0, t} - {1'b0, h};
        if (t < h)
        begin
            diff = diff + DEPTH_X;
        end
        return diff[PTR_W-1:0];
    endfunction

    // slot memory: one write port, one registered read port
    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_reg;
    logic [PTR_W-1:0]     raddr;
    logic                 we;
    logic [PTR_W-1:0]     waddr;
    logic [WORD_BITS-1:0] wdata;

    state_t               state_reg, state_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic [PTR_W-1:0]     lo_reg, lo_next;
    logic [PTR_W-1:0]     hi_reg, hi_next;
    logic [PTR_W-1:0]     pairs_reg, pairs_next;
    logic [WORD_BITS-1:0] tmp_reg, tmp_next;
    logic                 done_reg, done_next;
    cqrev_pkg::result_t   res_reg, res_next;

    logic                 accept;
    logic                 q_empty;
    logic                 q_full;
    logic [PTR_W-1:0]     cnt_now;
    logic [PTR_W-1:0]     cnt_next;
    logic [PTR_W+CW-1:0]  cnt_ext;
    logic [WORD_BITS+DW-1:0] in_ext;
    logic [WORD_BITS+DW-1:0] rd_ext;

    assign accept  = start && (state_reg == S_IDLE);
    assign q_empty = (head_reg == tail_reg);
    assign q_full  = (next_idx(tail_reg) == head_reg);
    assign cnt_now = held(head_reg, tail_reg);
    assign in_ext  = {{WORD_BITS{item.data_in[DW-1]}}, item.data_in};
    assign rd_ext  = {{DW{1'b0}}, rd_reg};

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        pairs_next = pairs_reg;
        tmp_next   = tmp_reg;
        done_next  = 1'b0;
        raddr      = head_reg;
        we         = 1'b0;
        waddr      = tail_reg;
        wdata      = in_ext[WORD_BITS-1:0];
        res_next   = res_reg;
        res_next.data_out = '0;
        res_next.status   = cqrev_pkg::ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.cmd)
                        cqrev_pkg::CMD_ENQ:
                        begin
                            done_next = 1'b1;
                            if (q_full)
                            begin
                                res_next.status = cqrev_pkg::ST_FULL;
                            end
                            else
                            begin
                                we        = 1'b1;
                                tail_next = next_idx(tail_reg);
                            end
                        end
                        cqrev_pkg::CMD_DEQ:
                        begin
                            // head word is being read this edge
                            if (q_empty)
                            begin
                                done_next       = 1'b1;
                                res_next.status = cqrev_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                head_next  = next_idx(head_reg);
                                state_next = S_DEQ;
                            end
                        end
                        cqrev_pkg::CMD_REV:
                        begin
                            lo_next    = head_reg;
                            hi_next    = prev_idx(tail_reg);
                            pairs_next = cnt_now >> 1;
                            if ((cnt_now >> 1) == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_REV_RD_LO;
                            end
                        end
                        cqrev_pkg::CMD_CLR:
                        begin
                            done_next = 1'b1;
                            head_next = '0;
                            tail_next = '0;
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            S_DEQ:
            begin
                done_next         = 1'b1;
                res_next.data_out = rd_ext[DW-1:0];
                state_next        = S_IDLE;
            end
            S_REV_RD_LO:
            begin
                raddr      = lo_reg;
                state_next = S_REV_RD_HI;
            end
            S_REV_RD_HI:
            begin
                raddr      = hi_reg;
                tmp_next   = rd_reg;
                state_next = S_REV_WR_LO;
            end
            S_REV_WR_LO:
            begin
                raddr      = lo_reg;
                we         = 1'b1;
                waddr      = lo_reg;
                wdata      = rd_reg;
                state_next = S_REV_WR_HI;
            end
            S_REV_WR_HI:
            begin
                raddr      = lo_reg;
                we         = 1'b1;
                waddr      = hi_reg;
                wdata      = tmp_reg;
                lo_next    = next_idx(lo_reg);
                hi_next    = prev_idx(hi_reg);
                pairs_next = pairs_reg - 1'b1;
                if (pairs_reg == PTR_W'(1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_REV_RD_LO;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        cnt_next            = held(head_next, tail_next);
        cnt_ext             = {{CW{1'b0}}, cnt_next};
        res_next.fill_count = cnt_ext[CW-1:0];
        res_next.is_empty   = (cnt_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            pairs_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            pairs_reg <= pairs_next;
            done_reg  <= done_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        tmp_reg <= tmp_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // results only leave from the idle state
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !done_reg)
        else $error("result strobe while sequencer busy");

    a_enq_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.cmd == cqrev_pkg::CMD_ENQ && !q_full) |=> (head_reg != tail_reg))
        else $error("queue empty after accepted enqueue");

    a_deq_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.cmd == cqrev_pkg::CMD_DEQ && !q_empty)
            |=> !done_reg ##1 (done_reg && res_reg.status == cqrev_pkg::ST_OK))
        else $error("dequeue result missing or not ok");

    a_swap_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REV_WR_HI) |-> (pairs_reg != '0))
        else $error("reverse swap with no pairs left");

    a_ptrs_fixed_rev: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REV_RD_LO) |=> ($stable(head_reg) && $stable(tail_reg)))
        else $error("pointers moved during reverse");

endmodule

@@ test/tb_circular_queue_with_reverse_top.sv @@
// Testbench for circular_queue_with_reverse_top: directed command table, then random traffic.
// Each transfer is scored against the plan's expected result or a ring-buffer predictor of the queue.
// Depends on cqrev_pkg and the circular_queue_with_reverse_top RTL.
module tb_circular_queue_with_reverse_top;

    localparam int QDEPTH       = 128;
    localparam int RAND_ITEMS   = 1750;
    localparam int CALM_TAIL    = 200;
    localparam int DRAIN_CYCLES = 260;   // longest reverse swaps 63 pairs
    localparam int STALL_LIMIT  = 3000;

    localparam cqrev_pkg::result_t EMPTY_OK = '{32'sd0, cqrev_pkg::ST_OK, 1'b1, 7'd0};
    localparam cqrev_pkg::result_t NO_RES   = '0;

    typedef struct {
        cqrev_pkg::cmd_t     cmd;
        logic signed [31:0]  data;
        int                  reps;
        bit                  typed;
        cqrev_pkg::result_t  want;
    } plan_row_t;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    cqrev_pkg::item_t   item  = '0;
    logic               busy;
    logic               done;
    cqrev_pkg::result_t result;

    // predictor state
    logic signed [31:0] ring [QDEPTH];
    logic [6:0]         head_ix = '0;
    logic [6:0]         tail_ix = '0;

    cqrev_pkg::result_t due_results[$];
    int      errors      = 0;
    int      idle_cycles = 0;
    bit      gaps_on     = 1'b1;

    circular_queue_with_reverse_top #(
        .DEPTH     (QDEPTH),
        .WORD_BITS (32)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one command to the predicted ring and returns the result it should give.
    function automatic cqrev_pkg::result_t ring_predict(input cqrev_pkg::cmd_t c,
                                                        input logic signed [31:0] d);
        cqrev_pkg::result_t r;
        logic [6:0]         n;
        logic [6:0]         a;
        logic [6:0]         b;
        logic signed [31:0] t;
        r = '0;
        r.status = cqrev_pkg::ST_OK;
        case (c)
            cqrev_pkg::CMD_ENQ:
            begin
                if (tail_ix + 7'd1 == head_ix)
                    r.status = cqrev_pkg::ST_FULL;
                else
                begin
                    ring[tail_ix] = d;
                    tail_ix = tail_ix + 7'd1;
                end
            end
            cqrev_pkg::CMD_DEQ:
            begin
                if (head_ix == tail_ix)
                    r.status = cqrev_pkg::ST_EMPTY;
                else
                begin
                    r.data_out = ring[head_ix];
                    head_ix = head_ix + 7'd1;
                end
            end
            cqrev_pkg::CMD_REV:
            begin
                n = tail_ix - head_ix;
                for (int k = 0; k < n / 2; k++)
                begin
                    a = head_ix + 7'(k);
                    b = head_ix + n - 7'd1 - 7'(k);
                    t = ring[a];
                    ring[a] = ring[b];
                    ring[b] = t;
                end
            end
            default:
            begin
                head_ix = '0;
                tail_ix = '0;
            end
        endcase
        n = tail_ix - head_ix;
        r.is_empty   = (n == 7'd0);
        r.fill_count = n;
        return r;
    endfunction

    // Holds the command until it transfers, then records what it should return.
    task automatic send_cmd(input cqrev_pkg::cmd_t c, input logic signed [31:0] d,
                            input bit typed, input cqrev_pkg::result_t want);
        cqrev_pkg::result_t pred;
        start <= 1'b1;
        item  <= '{cmd: c, data_in: d};
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        pred = ring_predict(c, d);
        due_results.push_back(typed ? want : pred);
    endtask

    task automatic maybe_idle(input bit allow);
        if (allow && $urandom_range(5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1))
                @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic flag_field(input string fname, input logic [31:0] want_v,
                              input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        cqrev_pkg::result_t want;
        if (rst_n && done)
        begin
            if (due_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got %p", $time, result);
            end
            else
            begin
                want = due_results.pop_front();
                flag_field("data_out", want.data_out, result.data_out);
                flag_field("status", 32'(want.status), 32'(result.status));
                flag_field("is_empty", 32'(want.is_empty), 32'(result.is_empty));
                flag_field("fill_count", 32'(want.fill_count), 32'(result.fill_count));
            end
        end
    end

    // stall watchdog: cycles with neither a command transfer nor a result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        plan_row_t          plan [25];
        int                 mode;
        int                 phase_left;
        int                 enq_lim;
        int                 r;
        cqrev_pkg::cmd_t    c;
        logic signed [31:0] d;

        plan = '{
            '{cqrev_pkg::CMD_DEQ, 32'sd0, 1, 1'b1, '{32'sd0, cqrev_pkg::ST_EMPTY, 1'b1, 7'd0}},
            '{cqrev_pkg::CMD_REV, 32'sd0, 1, 1'b1, EMPTY_OK},
            '{cqrev_pkg::CMD_CLR, 32'sd0, 1, 1'b1, EMPTY_OK},
            '{cqrev_pkg::CMD_ENQ, 32'sh7fffffff, 1, 1'b1, '{32'sd0, cqrev_pkg::ST_OK, 1'b0, 7'd1}},
            '{cqrev_pkg::CMD_ENQ, 32'sh80000000, 1, 1'b1, '{32'sd0, cqrev_pkg::ST_OK, 1'b0, 7'd2}},
            '{cqrev_pkg::CMD_ENQ, -32'sd1, 1, 1'b1, '{32'sd0, cqrev_pkg::ST_OK, 1'b0, 7'd3}},
            '{cqrev_pkg::CMD_ENQ, 32'sd0, 1, 1'b1, '{32'sd0, cqrev_pkg::ST_OK, 1'b0, 7'd4}},
            '{cqrev_pkg::CMD_REV, 32'sd0, 1, 1'b0, NO_RES},
            '{cqrev_pkg::CMD_DEQ, 32'sd0, 4, 1'b0, NO_RES},
            '{cqrev_pkg::CMD_DEQ, 32'sd0, 1, 1'b1, '{32'sd0, cqrev_pkg::ST_EMPTY, 1'b1, 7'd0}},
            '{cqrev_pkg::CMD_ENQ, 32'sd5, 1, 1'b1, '{32'sd0, cqrev_pkg::ST_OK, 1'b0, 7'd1}},
            '{cqrev_pkg::CMD_REV, 32'sd0, 1, 1'b1, '{32'sd0, cqrev_pkg::ST_OK, 1'b0, 7'd1}},
            '{cqrev_pkg::CMD_DEQ, 32'sd0, 1, 1'b1, '{32'sd5, cqrev_pkg::ST_OK, 1'b1, 7'd0}},
            '{cqrev_pkg::CMD_ENQ, 32'sd100, 127, 1'b0, NO_RES},
            '{cqrev_pkg::CMD_ENQ, 32'sh55aa55aa, 1, 1'b1,
              '{32'sd0, cqrev_pkg::ST_FULL, 1'b0, 7'd127}},
            '{cqrev_pkg::CMD_REV, 32'sd0, 1, 1'b0, NO_RES},
            '{cqrev_pkg::CMD_DEQ, 32'sd0, 3, 1'b0, NO_RES},
            '{cqrev_pkg::CMD_ENQ, 32'sh12345678, 2, 1'b0, NO_RES},
            '{cqrev_pkg::CMD_REV, 32'sd0, 1, 1'b0, NO_RES},
            '{cqrev_pkg::CMD_DEQ, 32'sd0, 2, 1'b0, NO_RES},
            '{cqrev_pkg::CMD_CLR, 32'sd0, 1, 1'b1, EMPTY_OK},
            '{cqrev_pkg::CMD_ENQ, 32'sh0f0f0f0f, 2, 1'b0, NO_RES},
            '{cqrev_pkg::CMD_REV, 32'sd0, 1, 1'b0, NO_RES},
            '{cqrev_pkg::CMD_DEQ, 32'sd0, 3, 1'b0, NO_RES},
            '{cqrev_pkg::CMD_REV, 32'sd0, 1, 1'b1, EMPTY_OK}
        };

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, full and empty rejects, reverse of 0/1/odd/even and wrapped
        foreach (plan[i])
        begin
            for (int j = 0; j < plan[i].reps; j++)
            begin
                send_cmd(plan[i].cmd, plan[i].data + j, plan[i].typed, plan[i].want);
                maybe_idle(1'b1);
            end
        end
        drain();

        // random: phases biased toward filling, draining or holding steady
        phase_left = 0;
        mode = 0;
        for (int k = 0; k < RAND_ITEMS; k++)
        begin
            if (phase_left == 0)
            begin
                mode       = $urandom_range(2);
                phase_left = $urandom_range(400, 100);
                gaps_on    = ($urandom_range(3) != 0);
            end
            phase_left--;
            enq_lim = (mode == 1) ? 800 : (mode == 2) ? 220 : 480;
            r = $urandom_range(999);
            if (r < enq_lim)
                c = cqrev_pkg::CMD_ENQ;
            else if (r < 968)
                c = cqrev_pkg::CMD_DEQ;
            else if (r < 998)
                c = cqrev_pkg::CMD_REV;
            else
                c = cqrev_pkg::CMD_CLR;
            if ($urandom_range(9) == 0)
            begin
                case ($urandom_range(3))
                    0:       d = 32'sh7fffffff;
                    1:       d = 32'sh80000000;
                    2:       d = 32'sd0;
                    default: d = -32'sd1;
                endcase
            end
            else
                d = $urandom;
            send_cmd(c, d, 1'b0, NO_RES);
            if (k == RAND_ITEMS / 2)
                drain();
            maybe_idle(gaps_on && k < RAND_ITEMS - CALM_TAIL);
        end

        drain();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/cqrev_pkg.sv
rtl/circular_queue_with_reverse_top.sv
test/tb_circular_queue_with_reverse_top.sv
